// ----- design/pffa_pkg.sv -----
package pffa_pkg;

    // default geometry
    localparam int DEF_GRID_SIDE   = 64;
    localparam int DEF_HEIGHT_BITS = 22;

    // fixed port widths
    localparam int REQ_W    = 2;
    localparam int IO_IDX_W = 12;
    localparam int IO_H_W   = 22;
    localparam int STEP_W   = 10;
    localparam int FLOW_W   = 13;

    // scratch width for height arithmetic
    localparam int WIDE_W = 34;

    localparam logic [STEP_W-1:0] STEP_RESET = 10'd1;
    localparam logic [FLOW_W-1:0] FLOW_ONE   = 13'd1;
    localparam logic [FLOW_W-1:0] FLOW_MAX   = 13'd8191;

    // request codes
    localparam logic [REQ_W-1:0] REQ_WRITE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_RUN   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

    // reply codes
    localparam logic REPLY_RUN  = 1'b0;
    localparam logic REPLY_READ = 1'b1;

    localparam logic signed [WIDE_W-1:0] OUT_H_MAX  = 34'sd2097151;
    localparam logic signed [WIDE_W-1:0] OUT_H_MIN  = -34'sd2097152;
    localparam logic signed [WIDE_W-1:0] DEPTH_MAX  = 34'sd4194303;
    localparam logic signed [WIDE_W-1:0] WIDE_ZERO  = 34'sd0;

    typedef struct packed {
        logic clear;
        logic push;
        logic pop;
    } heap_ctrl_t;

    typedef struct packed {
        logic done;
        logic empty;
    } heap_stat_t;

    function automatic logic signed [WIDE_W-1:0] clamp_wide(
        input logic signed [WIDE_W-1:0] v,
        input logic signed [WIDE_W-1:0] lo,
        input logic signed [WIDE_W-1:0] hi
    );
        logic signed [WIDE_W-1:0] r;
        if (v < lo)
        begin
            r = lo;
        end
        else if (v > hi)
        begin
            r = hi;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ----- design/pffa_heap.sv -----
module pffa_heap
    import pffa_pkg::*;
#(
    parameter int DEPTH = DEF_GRID_SIDE * DEF_GRID_SIDE,
    parameter int KEY_W = DEF_HEIGHT_BITS + 2 * $clog2(DEF_GRID_SIDE)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  heap_ctrl_t       ctrl,
    input  logic [KEY_W-1:0] key_in,
    output heap_stat_t       stat,
    output logic [KEY_W-1:0] top_key
);

    localparam int AW = $clog2(DEPTH);

    typedef enum logic [5:0] {
        HS_IDLE     = 6'b000001,
        HS_PUSH_RD  = 6'b000010,
        HS_PUSH_CMP = 6'b000100,
        HS_POP_LOAD = 6'b001000,
        HS_POP_RD   = 6'b010000,
        HS_POP_CMP  = 6'b100000
    } hstate_t;

    hstate_t          hstate_reg, hstate_next;
    logic [AW:0]      fill_reg, fill_next;
    logic             done_reg, done_next;
    logic [AW-1:0]    pos_reg, pos_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [KEY_W-1:0] top_reg, top_next;
    logic [KEY_W-1:0] rda_reg, rdb_reg;
    logic [KEY_W-1:0] heap_mem [DEPTH];

    logic             we;
    logic [AW-1:0]    waddr, raddr_a, raddr_b;
    logic [KEY_W-1:0] wdata;

    logic [AW-1:0]    parent;
    logic [AW+1:0]    lchild, rchild;
    logic             l_ok, r_ok, take_l, take_r;
    logic [KEY_W-1:0] cand;

    assign parent = (pos_reg - AW'(1)) >> 1;
    assign lchild = {1'b0, pos_reg, 1'b1};
    assign rchild = lchild + (AW+2)'(1);
    assign l_ok   = lchild < {1'b0, fill_reg};
    assign r_ok   = rchild < {1'b0, fill_reg};
    assign take_l = l_ok && (rda_reg < key_reg);
    assign cand   = take_l ? rda_reg : key_reg;
    assign take_r = r_ok && (rdb_reg < cand);

    always_comb
    begin
        hstate_next = hstate_reg;
        fill_next   = fill_reg;
        done_next   = 1'b0;
        pos_next    = pos_reg;
        key_next    = key_reg;
        top_next    = top_reg;
        we          = 1'b0;
        waddr       = pos_reg;
        wdata       = key_reg;
        raddr_a     = '0;
        raddr_b     = '0;
        unique case (hstate_reg)
            HS_IDLE:
            begin
                if (ctrl.clear)
                begin
                    fill_next = '0;
                end
                else if (ctrl.push)
                begin
                    key_next    = key_in;
                    pos_next    = fill_reg[AW-1:0];
                    fill_next   = fill_reg + (AW+1)'(1);
                    hstate_next = HS_PUSH_RD;
                end
                else if (ctrl.pop)
                begin
                    raddr_a     = '0;
                    raddr_b     = AW'(fill_reg - (AW+1)'(1));
                    fill_next   = fill_reg - (AW+1)'(1);
                    hstate_next = HS_POP_LOAD;
                end
            end
            HS_PUSH_RD:
            begin
                if (pos_reg == '0)
                begin
                    we          = 1'b1;
                    done_next   = 1'b1;
                    hstate_next = HS_IDLE;
                end
                else
                begin
                    raddr_a     = parent;
                    hstate_next = HS_PUSH_CMP;
                end
            end
            HS_PUSH_CMP:
            begin
                we = 1'b1;
                if (rda_reg > key_reg)
                begin
                    // move parent down into the hole
                    wdata       = rda_reg;
                    pos_next    = parent;
                    hstate_next = HS_PUSH_RD;
                end
                else
                begin
                    done_next   = 1'b1;
                    hstate_next = HS_IDLE;
                end
            end
            HS_POP_LOAD:
            begin
                top_next    = rda_reg;
                key_next    = rdb_reg;
                pos_next    = '0;
                hstate_next = HS_POP_RD;
            end
            HS_POP_RD:
            begin
                raddr_a     = l_ok ? lchild[AW-1:0] : '0;
                raddr_b     = r_ok ? rchild[AW-1:0] : '0;
                hstate_next = HS_POP_CMP;
            end
            HS_POP_CMP:
            begin
                we = 1'b1;
                if (take_r)
                begin
                    wdata       = rdb_reg;
                    pos_next    = rchild[AW-1:0];
                    hstate_next = HS_POP_RD;
                end
                else if (take_l)
                begin
                    wdata       = rda_reg;
                    pos_next    = lchild[AW-1:0];
                    hstate_next = HS_POP_RD;
                end
                else
                begin
                    done_next   = 1'b1;
                    hstate_next = HS_IDLE;
                end
            end
            default:
            begin
                hstate_next = HS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hstate_reg <= HS_IDLE;
            fill_reg   <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            hstate_reg <= hstate_next;
            fill_reg   <= fill_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        key_reg <= key_next;
        top_reg <= top_next;
        if (we)
        begin
            heap_mem[waddr] <= wdata;
        end
        rda_reg <= heap_mem[raddr_a];
        rdb_reg <= heap_mem[raddr_b];
    end

    assign stat.done  = done_reg;
    assign stat.empty = (fill_reg == '0);
    assign top_key    = top_reg;

endmodule

// ----- design/priority_flood_flow_accumulation_unit.sv -----
// priority-flood depression filling with d8 receivers and flow accumulation
// command channel: an item is taken when start is high and busy is low
//   req_type write: stores one terrain height, busy stays low
//   req_type read: busy in state S_READ only, reply strobed on done from a register set there
//   req_type run: busy for the whole run, then one reply with reply_kind run
//   request code three is dropped without a reply
// run length, roughly: an init sweep over all cells, then per border seed and
// per flooded cell a heap push that sifts level by level, per popped cell a
// heap pop that sifts level by level, 8 neighbor checks, and an accumulation
// step per border cell, longer per draining cell; heap sift depth and the
// neighbor scan set it
// done is high for exactly one cycle with the results on the result ports; the
// receiver cannot stall them
// cfg channel writes drainage_step when cfg_valid is high (cfg_ready is tied
// high); write it only while the block is idle
// reset clears the sequencer and sets drainage_step to 1; the grid stores
// hold nothing meaningful until written and a read before any run is
// undefined
module priority_flood_flow_accumulation_unit
    import pffa_pkg::*;
#(
    parameter int GRID_SIDE   = DEF_GRID_SIDE,
    parameter int HEIGHT_BITS = DEF_HEIGHT_BITS
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    // command channel
    input  logic                     start,
    output logic                     busy,
    input  logic [REQ_W-1:0]         req_type,
    input  logic [IO_IDX_W-1:0]      cell_index,
    input  logic signed [IO_H_W-1:0] height_in,
    // config channel
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [STEP_W-1:0]        cfg_data,
    // results
    output logic                     done,
    output logic                     reply_kind,
    output logic signed [IO_H_W-1:0] filled_height,
    output logic [IO_H_W-1:0]        fill_depth,
    output logic                     has_receiver,
    output logic [IO_IDX_W-1:0]      receiver_index,
    output logic [FLOW_W-1:0]        flow_count
);

    localparam int CELLS     = GRID_SIDE * GRID_SIDE;
    localparam int CELL_BITS = $clog2(CELLS);
    localparam int SB        = $clog2(GRID_SIDE);
    localparam int HB        = HEIGHT_BITS;
    localparam int KEY_W     = HB + 2 * SB;

    localparam logic signed [WIDE_W-1:0] H_MAX_W =
        WIDE_W'((64'sd1 <<< (HEIGHT_BITS - 1)) - 64'sd1);
    localparam logic signed [WIDE_W-1:0] H_MIN_W = -H_MAX_W - WIDE_W'(1);
    localparam logic [SB-1:0]       SIDE_M1 = SB'(GRID_SIDE - 1);
    localparam logic [SB:0]         SIDE_W  = (SB+1)'(GRID_SIDE);
    localparam logic [CELL_BITS:0]  CELLS_W = (CELL_BITS+1)'(CELLS);

    typedef enum logic [13:0] {
        S_IDLE      = 14'd1,
        S_READ      = 14'd2,
        S_INIT      = 14'd4,
        S_SEED      = 14'd8,
        S_SEED_KEY  = 14'd16,
        S_PUSH_WAIT = 14'd32,
        S_POP       = 14'd64,
        S_POP_WAIT  = 14'd128,
        S_NB_CHK    = 14'd256,
        S_NB_WR     = 14'd512,
        S_ACC_SEQ   = 14'd1024,
        S_ACC_LNK   = 14'd2048,
        S_ACC_RD    = 14'd4096,
        S_FINISH    = 14'd8192
    } state_t;

    function automatic logic [CELL_BITS-1:0] cell_of(
        input logic [SB-1:0] x,
        input logic [SB-1:0] z
    );
        return CELL_BITS'(32'(z) * GRID_SIDE + 32'(x));
    endfunction

    // sequencer state
    state_t               state_reg, state_next;
    logic [STEP_W-1:0]    step_reg;
    logic [CELL_BITS:0]   cnt_reg, cnt_next;
    logic [CELL_BITS:0]   pops_reg, pops_next;
    logic [SB-1:0]        seed_i_reg, seed_i_next;
    logic [1:0]           seed_ph_reg, seed_ph_next;
    logic [1:0]           dz_reg, dz_next, dx_reg, dx_next;
    logic                 from_seed_reg, from_seed_next;
    logic                 done_reg, done_next;

    // working payload
    logic [SB-1:0]          sx_reg, sx_next, sz_reg, sz_next;
    logic signed [HB-1:0]   cur_h_reg, cur_h_next;
    logic [SB-1:0]          cx_reg, cx_next, cz_reg, cz_next;
    logic [CELL_BITS-1:0]   cur_idx_reg, cur_idx_next;
    logic [SB-1:0]          nb_x_reg, nb_x_next, nb_z_reg, nb_z_next;
    logic [CELL_BITS-1:0]   nb_idx_reg, nb_idx_next;
    logic [CELL_BITS-1:0]   acc_r_reg, acc_r_next;
    logic [FLOW_W-1:0]      acc_fc_reg, acc_fc_next;
    logic                   rd_oob_reg, rd_oob_next;

    // result registers
    logic                     kind_reg, kind_next;
    logic signed [IO_H_W-1:0] fh_reg, fh_next;
    logic [IO_H_W-1:0]        fd_reg, fd_next;
    logic                     has_reg, has_next;
    logic [IO_IDX_W-1:0]      recv_reg, recv_next;
    logic [FLOW_W-1:0]        flow_reg, flow_next;

    // grid stores
    logic signed [HB-1:0]   terrain_mem [CELLS];
    logic signed [HB-1:0]   filled_mem [CELLS];
    logic                   visited_mem [CELLS];
    logic [CELL_BITS:0]     link_mem [CELLS];
    logic [FLOW_W-1:0]      flow_mem [CELLS];
    logic [CELL_BITS-1:0]   pop_mem [CELLS];

    logic signed [HB-1:0]   terrain_rd_reg, filled_rd_reg;
    logic                   visited_rd_reg;
    logic [CELL_BITS:0]     link_rd_reg;
    logic [FLOW_W-1:0]      flow_rd_reg;
    logic [CELL_BITS-1:0]   pop_rd_reg;

    logic                   terrain_we, filled_we, visited_we, link_we, flow_we, pop_we;
    logic [CELL_BITS-1:0]   terrain_waddr, filled_waddr, visited_waddr;
    logic [CELL_BITS-1:0]   link_waddr, flow_waddr, pop_waddr;
    logic [CELL_BITS-1:0]   terrain_raddr, filled_raddr, visited_raddr;
    logic [CELL_BITS-1:0]   link_raddr, flow_raddr, pop_raddr;
    logic signed [HB-1:0]   terrain_wdata, filled_wdata;
    logic                   visited_wdata;
    logic [CELL_BITS:0]     link_wdata;
    logic [FLOW_W-1:0]      flow_wdata;
    logic [CELL_BITS-1:0]   pop_wdata;

    // heap
    heap_ctrl_t       heap_ctrl;
    heap_stat_t       heap_stat;
    logic [KEY_W-1:0] heap_key, top_key;

    // helpers
    logic                   in_grid;
    logic [CELL_BITS-1:0]   req_idx;
    logic                   seed_last, seed_skip;
    logic [SB-1:0]          seed_x, seed_z;
    logic [1:0]             dx_adv, dz_adv;
    state_t                 seed_adv_state, nb_adv_state, acc_adv_state;
    logic [SB:0]            nx_p, nz_p;
    logic                   nb_ok;
    logic [SB-1:0]          nx, nz;
    logic signed [WIDE_W-1:0] raised, nb_old, new_fill, fwide, twide;
    logic signed [HB-1:0]   new_fill_h, top_h;
    logic [FLOW_W:0]        flow_sum;

    pffa_heap #(
        .DEPTH (CELLS),
        .KEY_W (KEY_W)
    ) u_heap (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (heap_ctrl),
        .key_in  (heap_key),
        .stat    (heap_stat),
        .top_key (top_key)
    );

    assign in_grid = 32'(cell_index) < CELLS;
    assign req_idx = CELL_BITS'(cell_index);

    // border walk: per index, row zero, last row, left and right column cells, columns minus corners
    always_comb
    begin
        case (seed_ph_reg)
            2'd0:
            begin
                seed_x = seed_i_reg;
                seed_z = '0;
            end
            2'd1:
            begin
                seed_x = seed_i_reg;
                seed_z = SIDE_M1;
            end
            2'd2:
            begin
                seed_x = '0;
                seed_z = seed_i_reg;
            end
            default:
            begin
                seed_x = SIDE_M1;
                seed_z = seed_i_reg;
            end
        endcase
    end

    assign seed_skip      = seed_ph_reg[1] && ((seed_i_reg == '0) || (seed_i_reg == SIDE_M1));
    assign seed_last      = (seed_ph_reg == 2'd3) && (seed_i_reg == SIDE_M1);
    assign seed_adv_state = seed_last ? S_POP : S_SEED;

    // neighbor scan, dz outer, dx inner
    assign dx_adv       = (dx_reg == 2'd2) ? 2'd0 : dx_reg + 2'd1;
    assign dz_adv       = (dx_reg == 2'd2) ? dz_reg + 2'd1 : dz_reg;
    assign nb_adv_state = ((dz_reg == 2'd2) && (dx_reg == 2'd2))
                          ? (heap_stat.empty ? S_ACC_SEQ : S_POP) : S_NB_CHK;
    assign acc_adv_state = (pops_reg == '0) ? S_FINISH : S_ACC_SEQ;

    assign nx_p  = {1'b0, cx_reg} + (SB+1)'(dx_reg);
    assign nz_p  = {1'b0, cz_reg} + (SB+1)'(dz_reg);
    assign nb_ok = !((dz_reg == 2'd1) && (dx_reg == 2'd1))
                   && (nx_p != '0) && (nx_p <= SIDE_W)
                   && (nz_p != '0) && (nz_p <= SIDE_W);
    assign nx    = SB'(nx_p - (SB+1)'(1));
    assign nz    = SB'(nz_p - (SB+1)'(1));

    // raise flooded neighbor to at least popped height plus step, saturating
    assign raised     = clamp_wide(WIDE_W'(cur_h_reg) + WIDE_W'($signed({1'b0, step_reg})),
                                   H_MIN_W, H_MAX_W);
    assign nb_old     = WIDE_W'(filled_rd_reg);
    assign new_fill   = (raised > nb_old) ? raised : nb_old;
    assign new_fill_h = HB'(new_fill);

    // keys order by biased height, then row, then column, i.e. by cell index
    assign top_h = {~top_key[KEY_W-1], top_key[KEY_W-2 -: HB-1]};

    assign fwide    = WIDE_W'(filled_rd_reg);
    assign twide    = WIDE_W'(terrain_rd_reg);
    assign flow_sum = {1'b0, flow_rd_reg} + {1'b0, acc_fc_reg};

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        pops_next      = pops_reg;
        seed_i_next    = seed_i_reg;
        seed_ph_next   = seed_ph_reg;
        dz_next        = dz_reg;
        dx_next        = dx_reg;
        from_seed_next = from_seed_reg;
        done_next      = 1'b0;
        sx_next        = sx_reg;
        sz_next        = sz_reg;
        cur_h_next     = cur_h_reg;
        cx_next        = cx_reg;
        cz_next        = cz_reg;
        cur_idx_next   = cur_idx_reg;
        nb_x_next      = nb_x_reg;
        nb_z_next      = nb_z_reg;
        nb_idx_next    = nb_idx_reg;
        acc_r_next     = acc_r_reg;
        acc_fc_next    = acc_fc_reg;
        rd_oob_next    = rd_oob_reg;
        kind_next      = kind_reg;
        fh_next        = fh_reg;
        fd_next        = fd_reg;
        has_next       = has_reg;
        recv_next      = recv_reg;
        flow_next      = flow_reg;

        terrain_we    = 1'b0;
        terrain_waddr = req_idx;
        terrain_wdata = HB'(clamp_wide(WIDE_W'(height_in), H_MIN_W, H_MAX_W));
        terrain_raddr = req_idx;
        filled_we     = 1'b0;
        filled_waddr  = nb_idx_reg;
        filled_wdata  = new_fill_h;
        filled_raddr  = req_idx;
        visited_we    = 1'b0;
        visited_waddr = nb_idx_reg;
        visited_wdata = 1'b1;
        visited_raddr = nb_idx_reg;
        link_we       = 1'b0;
        link_waddr    = nb_idx_reg;
        link_wdata    = {1'b1, cur_idx_reg};
        link_raddr    = req_idx;
        flow_we       = 1'b0;
        flow_waddr    = acc_r_reg;
        flow_wdata    = flow_sum[FLOW_W] ? FLOW_MAX : flow_sum[FLOW_W-1:0];
        flow_raddr    = req_idx;
        pop_we        = 1'b0;
        pop_waddr     = pops_reg[CELL_BITS-1:0];
        pop_wdata     = cell_of(top_key[SB-1:0], top_key[2*SB-1:SB]);
        pop_raddr     = CELL_BITS'(pops_reg - (CELL_BITS+1)'(1));

        heap_ctrl = '0;
        heap_key  = {~new_fill_h[HB-1], new_fill_h[HB-2:0], nb_z_reg, nb_x_reg};

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (req_type)
                        REQ_WRITE:
                        begin
                            terrain_we = in_grid;
                        end
                        REQ_RUN:
                        begin
                            cnt_next       = '0;
                            heap_ctrl.clear = 1'b1;
                            state_next     = S_INIT;
                        end
                        REQ_READ:
                        begin
                            rd_oob_next = !in_grid;
                            state_next  = S_READ;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                kind_next = REPLY_READ;
                if (rd_oob_reg)
                begin
                    fh_next   = '0;
                    fd_next   = '0;
                    has_next  = 1'b0;
                    recv_next = '0;
                    flow_next = '0;
                end
                else
                begin
                    fh_next   = IO_H_W'(clamp_wide(fwide, OUT_H_MIN, OUT_H_MAX));
                    fd_next   = IO_H_W'(clamp_wide(fwide - twide, WIDE_ZERO, DEPTH_MAX));
                    has_next  = link_rd_reg[CELL_BITS];
                    recv_next = link_rd_reg[CELL_BITS] ?
                                IO_IDX_W'(link_rd_reg[CELL_BITS-1:0]) : '0;
                    flow_next = flow_rd_reg;
                end
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            S_INIT:
            begin
                // copy terrain into filled from the registered read of the previous index, reset the rest
                terrain_raddr = cnt_reg[CELL_BITS-1:0];
                filled_waddr  = CELL_BITS'(cnt_reg - (CELL_BITS+1)'(1));
                filled_wdata  = terrain_rd_reg;
                filled_we     = (cnt_reg != '0);
                visited_we    = (cnt_reg != CELLS_W);
                visited_waddr = cnt_reg[CELL_BITS-1:0];
                visited_wdata = 1'b0;
                link_we       = (cnt_reg != CELLS_W);
                link_waddr    = cnt_reg[CELL_BITS-1:0];
                link_wdata    = '0;
                flow_we       = (cnt_reg != CELLS_W);
                flow_waddr    = cnt_reg[CELL_BITS-1:0];
                flow_wdata    = FLOW_ONE;
                cnt_next      = cnt_reg + (CELL_BITS+1)'(1);
                if (cnt_reg == CELLS_W)
                begin
                    seed_i_next  = '0;
                    seed_ph_next = 2'd0;
                    pops_next    = '0;
                    state_next   = S_SEED;
                end
            end
            S_SEED:
            begin
                if (seed_skip)
                begin
                    seed_ph_next = seed_ph_reg + 2'd1;
                    seed_i_next  = (seed_ph_reg == 2'd3) ? seed_i_reg + SB'(1) : seed_i_reg;
                    state_next   = seed_adv_state;
                end
                else
                begin
                    filled_raddr  = cell_of(seed_x, seed_z);
                    visited_we    = 1'b1;
                    visited_waddr = cell_of(seed_x, seed_z);
                    sx_next       = seed_x;
                    sz_next       = seed_z;
                    state_next    = S_SEED_KEY;
                end
            end
            S_SEED_KEY:
            begin
                heap_key       = {~filled_rd_reg[HB-1], filled_rd_reg[HB-2:0], sz_reg, sx_reg};
                heap_ctrl.push = 1'b1;
                from_seed_next = 1'b1;
                state_next     = S_PUSH_WAIT;
            end
            S_PUSH_WAIT:
            begin
                if (heap_stat.done)
                begin
                    if (from_seed_reg)
                    begin
                        seed_ph_next = seed_ph_reg + 2'd1;
                        seed_i_next  = (seed_ph_reg == 2'd3) ? seed_i_reg + SB'(1) : seed_i_reg;
                        state_next   = seed_adv_state;
                    end
                    else
                    begin
                        dx_next    = dx_adv;
                        dz_next    = dz_adv;
                        state_next = nb_adv_state;
                    end
                end
            end
            S_POP:
            begin
                heap_ctrl.pop = 1'b1;
                state_next    = S_POP_WAIT;
            end
            S_POP_WAIT:
            begin
                if (heap_stat.done)
                begin
                    cur_h_next   = top_h;
                    cx_next      = top_key[SB-1:0];
                    cz_next      = top_key[2*SB-1:SB];
                    cur_idx_next = pop_wdata;
                    pop_we       = 1'b1;
                    pops_next    = pops_reg + (CELL_BITS+1)'(1);
                    dz_next      = 2'd0;
                    dx_next      = 2'd0;
                    state_next   = S_NB_CHK;
                end
            end
            S_NB_CHK:
            begin
                if (nb_ok)
                begin
                    visited_raddr = cell_of(nx, nz);
                    filled_raddr  = cell_of(nx, nz);
                    nb_x_next     = nx;
                    nb_z_next     = nz;
                    nb_idx_next   = cell_of(nx, nz);
                    state_next    = S_NB_WR;
                end
                else
                begin
                    dx_next    = dx_adv;
                    dz_next    = dz_adv;
                    state_next = nb_adv_state;
                end
            end
            S_NB_WR:
            begin
                if (!visited_rd_reg)
                begin
                    visited_we     = 1'b1;
                    link_we        = 1'b1;
                    filled_we      = 1'b1;
                    heap_ctrl.push = 1'b1;
                    from_seed_next = 1'b0;
                    state_next     = S_PUSH_WAIT;
                end
                else
                begin
                    dx_next    = dx_adv;
                    dz_next    = dz_adv;
                    state_next = nb_adv_state;
                end
            end
            S_ACC_SEQ:
            begin
                // walk the pop order backwards, donors before receivers
                pops_next  = pops_reg - (CELL_BITS+1)'(1);
                state_next = S_ACC_LNK;
            end
            S_ACC_LNK:
            begin
                link_raddr = pop_rd_reg;
                flow_raddr = pop_rd_reg;
                state_next = S_ACC_RD;
            end
            S_ACC_RD:
            begin
                if (from_seed_reg)
                begin
                    // receiver count has arrived, add the donor into it
                    flow_we        = 1'b1;
                    from_seed_next = 1'b0;
                    state_next     = acc_adv_state;
                end
                else if (link_rd_reg[CELL_BITS])
                begin
                    acc_r_next     = link_rd_reg[CELL_BITS-1:0];
                    acc_fc_next    = flow_rd_reg;
                    flow_raddr     = link_rd_reg[CELL_BITS-1:0];
                    from_seed_next = 1'b1;
                    state_next     = S_ACC_RD;
                end
                else
                begin
                    state_next = acc_adv_state;
                end
            end
            S_FINISH:
            begin
                kind_next  = REPLY_RUN;
                fh_next    = '0;
                fd_next    = '0;
                has_next   = 1'b0;
                recv_next  = '0;
                flow_next  = '0;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= STEP_RESET;
            cnt_reg       <= '0;
            pops_reg      <= '0;
            seed_i_reg    <= '0;
            seed_ph_reg   <= '0;
            dz_reg        <= '0;
            dx_reg        <= '0;
            from_seed_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pops_reg      <= pops_next;
            seed_i_reg    <= seed_i_next;
            seed_ph_reg   <= seed_ph_next;
            dz_reg        <= dz_next;
            dx_reg        <= dx_next;
            from_seed_reg <= from_seed_next;
            done_reg      <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                step_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sx_reg      <= sx_next;
        sz_reg      <= sz_next;
        cur_h_reg   <= cur_h_next;
        cx_reg      <= cx_next;
        cz_reg      <= cz_next;
        cur_idx_reg <= cur_idx_next;
        nb_x_reg    <= nb_x_next;
        nb_z_reg    <= nb_z_next;
        nb_idx_reg  <= nb_idx_next;
        acc_r_reg   <= acc_r_next;
        acc_fc_reg  <= acc_fc_next;
        rd_oob_reg  <= rd_oob_next;
        kind_reg    <= kind_next;
        fh_reg      <= fh_next;
        fd_reg      <= fd_next;
        has_reg     <= has_next;
        recv_reg    <= recv_next;
        flow_reg    <= flow_next;
    end

    // grid stores: one write and one registered read each
    always_ff @(posedge clk)
    begin
        if (terrain_we)
        begin
            terrain_mem[terrain_waddr] <= terrain_wdata;
        end
        terrain_rd_reg <= terrain_mem[terrain_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (filled_we)
        begin
            filled_mem[filled_waddr] <= filled_wdata;
        end
        filled_rd_reg <= filled_mem[filled_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (visited_we)
        begin
            visited_mem[visited_waddr] <= visited_wdata;
        end
        visited_rd_reg <= visited_mem[visited_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
        link_rd_reg <= link_mem[link_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (flow_we)
        begin
            flow_mem[flow_waddr] <= flow_wdata;
        end
        flow_rd_reg <= flow_mem[flow_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (pop_we)
        begin
            pop_mem[pop_waddr] <= pop_wdata;
        end
        pop_rd_reg <= pop_mem[pop_raddr];
    end

    assign busy           = (state_reg != S_IDLE);
    assign cfg_ready      = 1'b1;
    assign done           = done_reg;
    assign reply_kind     = kind_reg;
    assign filled_height  = fh_reg;
    assign fill_depth     = fd_reg;
    assign has_receiver   = has_reg;
    assign receiver_index = recv_reg;
    assign flow_count     = flow_reg;

endmodule
